FILE: hdl/fgn_pkg.sv
package fgn_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int MAX_OCTAVES_HI  = 16;
  localparam int ONE             = 1 << FRAC_BITS;

  localparam int COORD_W = 32;
  localparam int FREQ_W  = 32;
  localparam int AMP_W   = 32;
  localparam int SEED_W  = 32;
  localparam int PERS_W  = 18;
  localparam int LAC_W   = 20;
  localparam int OCT_W   = 4;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int OUT_W   = 18;

  localparam int REM_W   = $clog2(MAX_OCTAVES_HI + 1);
  localparam int FW      = FRAC_BITS + 2;
  localparam int LW      = FRAC_BITS + 6;
  localparam int NOISE_W = FRAC_BITS + 3;
  localparam int PROD_W  = NOISE_W + AMP_W + 1;
  localparam int ACC_W   = PROD_W + $clog2(MAX_OCTAVES_HI);
  localparam int TOT_W   = AMP_W + $clog2(MAX_OCTAVES_HI);
  localparam int QUOT_W  = NOISE_W;
  localparam int CELL_LAT = 8;

  localparam logic [31:0] HASH_KX = 32'd73856093;
  localparam logic [31:0] HASH_KY = 32'd19349663;
  localparam logic [31:0] HASH_KS = 32'd83492791;
  localparam logic [31:0] HASH_KM = 32'd1274126177;
  localparam int HASH_SHIFT = 13;

  localparam logic [OCT_W-1:0]  RST_OCTAVES = 4'd4;
  localparam logic [FREQ_W-1:0] RST_FREQ    = 32'd65536;
  localparam logic [PERS_W-1:0] RST_PERS    = 18'd32768;
  localparam logic [LAC_W-1:0]  RST_LAC     = 20'd131072;

  typedef enum logic [IDX_W-1:0] {
    CFG_OCTAVES = 3'd0,
    CFG_MODE    = 3'd1,
    CFG_SEED    = 3'd2,
    CFG_FREQ    = 3'd3,
    CFG_PERS    = 3'd4,
    CFG_LAC     = 3'd5
  } cfg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_RIDGED = 2'd1,
    MODE_BILLOW = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    GRAD_PP = 2'd0,
    GRAD_NP = 2'd1,
    GRAD_PN = 2'd2,
    GRAD_NN = 2'd3
  } grad_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PERS_W-1:0] pers;
    logic [LAC_W-1:0]  lac;
  } cell_cfg_t;

  typedef struct packed {
    logic                       valid;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [FREQ_W-1:0]          freq;
    logic [AMP_W-1:0]           amp;
    logic [SEED_W-1:0]          seed;
    logic [REM_W-1:0]           rem;
    logic signed [ACC_W-1:0]    acc;
    logic [TOT_W-1:0]           total;
  } chain_t;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic [ACC_W-1:0]  rem;
    logic [TOT_W-1:0]  total;
    logic [QUOT_W-1:0] q;
  } div_t;

  function automatic logic signed [NOISE_W-1:0] grad_dot(
      logic [1:0] g, logic signed [FW-1:0] dx, logic signed [FW-1:0] dy);
    logic signed [NOISE_W-1:0] ex;
    logic signed [NOISE_W-1:0] ey;
    logic signed [NOISE_W-1:0] r;
    ex = dx;
    ey = dy;
    unique case (grad_t'(g))
      GRAD_PP: r = ex + ey;
      GRAD_NP: r = ey - ex;
      GRAD_PN: r = ex - ey;
      GRAD_NN: r = -ex - ey;
    endcase
    return r;
  endfunction

  function automatic logic signed [NOISE_W-1:0] lerp(
      logic signed [NOISE_W-1:0] a, logic signed [NOISE_W-1:0] b,
      logic signed [FW-1:0] w);
    logic signed [NOISE_W:0]    diff;
    logic signed [NOISE_W+FW:0] p;
    diff = b - a;
    p    = diff * w;
    return a + $signed(p[FRAC_BITS+NOISE_W-1:FRAC_BITS]);
  endfunction

endpackage

FILE: hdl/fgn_octave.sv
module fgn_octave (
  input  logic               clk,
  input  logic               rst,
  input  fgn_pkg::cell_cfg_t cfg,
  input  fgn_pkg::chain_t    din,
  output fgn_pkg::chain_t    dout
);
  import fgn_pkg::*;

  localparam int F = FRAC_BITS;

  chain_t line      [1:CELL_LAT-1];
  chain_t line_next [1:CELL_LAT-1];

  always_comb begin
    line_next[1] = din;
    for (int k = 2; k < CELL_LAT; k++) begin
      line_next[k] = line[k-1];
    end
    if (rst) begin
      for (int k = 1; k < CELL_LAT; k++) begin
        line_next[k].valid = 1'b0;
      end
    end
  end

  // A: scale coordinate by frequency
  logic signed [COORD_W+FREQ_W:0] px_full, py_full;
  logic [COORD_W+FREQ_W-1:F] px_a, py_a;

  assign px_full = din.x * $signed({1'b0, din.freq});
  assign py_full = din.y * $signed({1'b0, din.freq});

  // B: lattice hash products, fade partials
  logic [F-1:0]  fx, fy;
  logic [31:0]   x0, y0, x1, y1, kx0, kx1, ky0, ky1, ks;
  logic [2*F-1:0] sqx, sqy;
  logic signed [LW-1:0] largx, largy;
  logic signed [F+LW:0] linx_full, liny_full;

  logic [31:0]          b_h [4];
  logic [F-1:0]         b_fx, b_fy, b_t2x, b_t2y;
  logic signed [LW-1:0] b_linx, b_liny;

  assign fx  = px_a[2*F-1:F];
  assign fy  = py_a[2*F-1:F];
  assign x0  = px_a[COORD_W+FREQ_W-1:2*F];
  assign y0  = py_a[COORD_W+FREQ_W-1:2*F];
  assign x1  = x0 + 32'd1;
  assign y1  = y0 + 32'd1;
  assign kx0 = x0 * HASH_KX;
  assign kx1 = x1 * HASH_KX;
  assign ky0 = y0 * HASH_KY;
  assign ky1 = y1 * HASH_KY;
  assign ks  = line[1].seed * HASH_KS;
  assign sqx = fx * fx;
  assign sqy = fy * fy;
  assign largx = $signed(LW'(6 * fx)) - $signed(LW'(15 * ONE));
  assign largy = $signed(LW'(6 * fy)) - $signed(LW'(15 * ONE));
  assign linx_full = $signed({1'b0, fx}) * largx;
  assign liny_full = $signed({1'b0, fy}) * largy;

  // C: hash finish, cube and inner polynomial
  logic [31:0]          hs [4];
  logic [31:0]          hm [4];
  logic [2*F-1:0]       cubx, cuby;
  logic [1:0]           c_g [4];
  logic [F-1:0]         c_fx, c_fy, c_t3x, c_t3y;
  logic signed [LW-1:0] c_innx, c_inny;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hs[c] = b_h[c] ^ 32'($signed(b_h[c]) >>> HASH_SHIFT);
      hm[c] = hs[c] * HASH_KM;
    end
  end

  assign cubx = b_t2x * b_fx;
  assign cuby = b_t2y * b_fy;

  // D: fade weights, corner dots
  logic signed [F+LW:0] ux_full, uy_full;
  logic signed [FW-1:0] dx0, dx1, dy0, dy1;
  logic signed [FW-1:0] d_u, d_v;
  logic signed [NOISE_W-1:0] d_n [4];

  assign ux_full = $signed({1'b0, c_t3x}) * c_innx;
  assign uy_full = $signed({1'b0, c_t3y}) * c_inny;
  assign dx0 = $signed({2'b00, c_fx});
  assign dy0 = $signed({2'b00, c_fy});
  assign dx1 = dx0 - FW'(ONE);
  assign dy1 = dy0 - FW'(ONE);

  // E, F: interpolation and mode
  logic signed [NOISE_W-1:0] e_a0, e_a1, f_m, n_f, an_f, m_f;
  logic signed [FW-1:0]      e_v;

  assign n_f  = lerp(e_a0, e_a1, e_v);
  assign an_f = n_f[NOISE_W-1] ? -n_f : n_f;

  always_comb begin
    unique case (mode_t'(cfg.mode))
      MODE_RIDGED: m_f = $signed(NOISE_W'(ONE)) - an_f;
      MODE_BILLOW: m_f = an_f;
      default:     m_f = n_f;
    endcase
  end

  // G: weight by amplitude
  logic signed [PROD_W-1:0] g_prod;

  // H: accumulate, step frequency and amplitude
  logic                          active;
  logic [FREQ_W+LAC_W-1:0]       freq_full;
  logic [AMP_W+PERS_W-1:0]       amp_full;
  logic [FREQ_W+LAC_W-1:F]       freq_sh;
  logic [AMP_W+PERS_W-1:F]       amp_sh;
  logic [FREQ_W-1:0]             freq_next;
  logic [AMP_W-1:0]              amp_next;

  assign active    = line[CELL_LAT-1].rem != '0;
  assign freq_full = line[CELL_LAT-1].freq * cfg.lac;
  assign amp_full  = line[CELL_LAT-1].amp * cfg.pers;
  assign freq_sh   = freq_full[FREQ_W+LAC_W-1:F];
  assign amp_sh    = amp_full[AMP_W+PERS_W-1:F];
  assign freq_next = (|freq_sh[FREQ_W+LAC_W-1:F+FREQ_W]) ? '1 : freq_sh[F+FREQ_W-1:F];
  assign amp_next  = (|amp_sh[AMP_W+PERS_W-1:F+AMP_W]) ? '1 : amp_sh[F+AMP_W-1:F];

  always_ff @(posedge clk) begin
    for (int k = 1; k < CELL_LAT; k++) begin
      line[k] <= line_next[k];
    end

    px_a <= px_full[COORD_W+FREQ_W-1:F];
    py_a <= py_full[COORD_W+FREQ_W-1:F];

    b_h[0] <= kx0 ^ ky0 ^ ks;
    b_h[1] <= kx1 ^ ky0 ^ ks;
    b_h[2] <= kx0 ^ ky1 ^ ks;
    b_h[3] <= kx1 ^ ky1 ^ ks;
    b_fx   <= fx;
    b_fy   <= fy;
    b_t2x  <= sqx[2*F-1:F];
    b_t2y  <= sqy[2*F-1:F];
    b_linx <= linx_full[F+LW-1:F];
    b_liny <= liny_full[F+LW-1:F];

    for (int c = 0; c < 4; c++) begin
      c_g[c] <= hm[c][1:0];
    end
    c_fx   <= b_fx;
    c_fy   <= b_fy;
    c_t3x  <= cubx[2*F-1:F];
    c_t3y  <= cuby[2*F-1:F];
    c_innx <= b_linx + $signed(LW'(10 * ONE));
    c_inny <= b_liny + $signed(LW'(10 * ONE));

    d_u    <= ux_full[F+FW-1:F];
    d_v    <= uy_full[F+FW-1:F];
    d_n[0] <= grad_dot(c_g[0], dx0, dy0);
    d_n[1] <= grad_dot(c_g[1], dx1, dy0);
    d_n[2] <= grad_dot(c_g[2], dx0, dy1);
    d_n[3] <= grad_dot(c_g[3], dx1, dy1);

    e_a0 <= lerp(d_n[0], d_n[1], d_u);
    e_a1 <= lerp(d_n[2], d_n[3], d_u);
    e_v  <= d_v;

    f_m <= m_f;

    g_prod <= f_m * $signed({1'b0, line[CELL_LAT-2].amp});

    dout.valid <= line[CELL_LAT-1].valid && !rst;
    dout.x     <= line[CELL_LAT-1].x;
    dout.y     <= line[CELL_LAT-1].y;
    dout.seed  <= line[CELL_LAT-1].seed + 32'd1;
    dout.freq  <= freq_next;
    dout.amp   <= amp_next;
    dout.rem   <= line[CELL_LAT-1].rem - REM_W'(active);
    dout.acc   <= active ? line[CELL_LAT-1].acc + g_prod : line[CELL_LAT-1].acc;
    dout.total <= active ? line[CELL_LAT-1].total + TOT_W'(line[CELL_LAT-1].amp)
                         : line[CELL_LAT-1].total;
  end

endmodule

FILE: hdl/fgn_div_cell.sv
module fgn_div_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  fgn_pkg::div_t din,
  output fgn_pkg::div_t dout
);
  import fgn_pkg::*;

  logic [ACC_W-1:0] shd;
  logic             take;
  div_t             dout_next;

  assign shd  = ACC_W'(din.total) << BIT;
  assign take = (din.rem >= shd) && (din.total != '0);

  always_comb begin
    dout_next        = din;
    dout_next.rem    = take ? din.rem - shd : din.rem;
    dout_next.q[BIT] = take;
    if (rst) begin
      dout_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

FILE: hdl/fractal_gradient_noise_core.sv
// Throughput: one word per cycle; busy is low whenever rst is low.
// Each octave is an 8-stage cell in a chain; a 19-stage restoring divider
// normalizes by the weight sum. done pulses for one cycle; no stall.
// Reset: synchronous rst clears the pipeline and loads register defaults.
module fractal_gradient_noise_core #(
  parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [fgn_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [fgn_pkg::COORD_W-1:0]  y_coord,
  output logic                                done,
  output logic signed [fgn_pkg::OUT_W-1:0]    noise_value,
  input  logic                                cfg_we,
  input  logic [fgn_pkg::IDX_W-1:0]           cfg_index,
  input  logic [fgn_pkg::CFG_W-1:0]           cfg_data
);
  import fgn_pkg::*;

  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;

  logic [OCT_W-1:0]  octave_count;
  logic [MODE_W-1:0] noise_mode;
  logic [SEED_W-1:0] seed;
  logic [FREQ_W-1:0] base_frequency;
  logic [PERS_W-1:0] persistence;
  logic [LAC_W-1:0]  lacunarity;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count   <= RST_OCTAVES;
      noise_mode     <= MODE_PLAIN;
      seed           <= '0;
      base_frequency <= RST_FREQ;
      persistence    <= RST_PERS;
      lacunarity     <= RST_LAC;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_OCTAVES: octave_count   <= cfg_data[OCT_W-1:0];
        CFG_MODE:    noise_mode     <= cfg_data[MODE_W-1:0];
        CFG_SEED:    seed           <= cfg_data[SEED_W-1:0];
        CFG_FREQ:    base_frequency <= cfg_data[FREQ_W-1:0];
        CFG_PERS:    persistence    <= cfg_data[PERS_W-1:0];
        CFG_LAC:     lacunarity     <= cfg_data[LAC_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  cell_cfg_t ccfg;
  chain_t    links [0:MAX_OCTAVES];

  assign ccfg.mode = noise_mode;
  assign ccfg.pers = persistence;
  assign ccfg.lac  = lacunarity;

  always_comb begin
    links[0].valid = start && !busy;
    links[0].x     = x_coord;
    links[0].y     = y_coord;
    links[0].freq  = base_frequency;
    links[0].amp   = AMP_W'(ONE);
    links[0].seed  = seed;
    links[0].rem   = (32'(octave_count) > MAX_OCTAVES) ? REM_W'(MAX_OCTAVES)
                                                       : REM_W'(octave_count);
    links[0].acc   = '0;
    links[0].total = '0;
  end

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fgn_octave u_oct (
      .clk  (clk),
      .rst  (rst),
      .cfg  (ccfg),
      .din  (links[i]),
      .dout (links[i+1])
    );
  end

  div_t dv [0:QUOT_W];

  always_ff @(posedge clk) begin
    dv[0].valid <= links[MAX_OCTAVES].valid && !rst;
    dv[0].neg   <= links[MAX_OCTAVES].acc[ACC_W-1];
    dv[0].rem   <= links[MAX_OCTAVES].acc[ACC_W-1] ? -links[MAX_OCTAVES].acc
                                                   : links[MAX_OCTAVES].acc;
    dv[0].total <= links[MAX_OCTAVES].total;
    dv[0].q     <= '0;
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    fgn_div_cell #(.BIT(QUOT_W - 1 - k)) u_div (
      .clk  (clk),
      .rst  (rst),
      .din  (dv[k]),
      .dout (dv[k+1])
    );
  end

  logic signed [QUOT_W:0]  sq;
  logic signed [OUT_W-1:0] sat_val;

  assign sq = dv[QUOT_W].neg ? -$signed({1'b0, dv[QUOT_W].q}) : $signed({1'b0, dv[QUOT_W].q});

  always_comb begin
    if (sq > OUT_MAX) begin
      sat_val = OUT_W'(OUT_MAX);
    end else if (sq < -(OUT_MAX + 1)) begin
      sat_val = OUT_W'(-(OUT_MAX + 1));
    end else begin
      sat_val = sq[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    noise_value <= sat_val;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[QUOT_W].valid;
    end
  end

endmodule

FILE: hdl/fgn_checker.sv
module fgn_checker #(
  parameter int LAT = 85
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_ready_out_of_reset: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy high out of reset");

  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("done without a word accepted at the fixed latency");

  a_reset_quiets: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");

endmodule

bind fractal_gradient_noise_core fgn_checker #(
  .LAT(fgn_pkg::CELL_LAT * MAX_OCTAVES + fgn_pkg::QUOT_W + 2)
) u_fgn_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

FILE: dv/fractal_gradient_noise_core_tb.sv
module fractal_gradient_noise_core_tb;
  import fgn_pkg::*;

  localparam logic [IDX_W-1:0] CFG_SPARE = 3'd6;
  localparam logic [IDX_W-1:0] CFG_TOP   = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } sample_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic signed [COORD_W-1:0]  x_coord;
  logic signed [COORD_W-1:0]  y_coord;
  logic                       done;
  logic signed [OUT_W-1:0]    noise_value;
  logic                       cfg_we;
  logic [IDX_W-1:0]           cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  fractal_gradient_noise_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_coord(x_coord), .y_coord(y_coord), .done(done),
    .noise_value(noise_value), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow registers
  logic [OCT_W-1:0]  oct_r;
  logic [MODE_W-1:0] mode_r;
  logic [SEED_W-1:0] seed_r;
  logic [FREQ_W-1:0] freq_r;
  logic [PERS_W-1:0] pers_r;
  logic [LAC_W-1:0]  lac_r;

  sample_t                 samples_pending[$];
  logic signed [OUT_W-1:0] noise_expected[$];
  int  mismatches;
  int  idle_left;
  bit  no_idle;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function automatic longint quintic(longint t);
    longint t3;
    longint inner;
    t3 = fx_mul(fx_mul(t, t), t);
    inner = fx_mul(t, 6 * t - 15 * longint'(ONE)) + 10 * longint'(ONE);
    return fx_mul(t3, inner);
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return a + fx_mul(b - a, w);
  endfunction

  function automatic logic [31:0] corner_hash(logic [31:0] cx, logic [31:0] cy,
                                              logic [31:0] s);
    logic [31:0]        h;
    logic signed [31:0] hs;
    h  = (cx * HASH_KX) ^ (cy * HASH_KY) ^ (s * HASH_KS);
    hs = h;
    hs = hs >>> HASH_SHIFT;
    h  = h ^ hs;
    return h * HASH_KM;
  endfunction

  function automatic longint corner_dot(logic [31:0] h, longint dx, longint dy);
    case (grad_t'(h[1:0]))
      GRAD_PP: return dx + dy;
      GRAD_NP: return -dx + dy;
      GRAD_PN: return dx - dy;
      default: return -dx - dy;
    endcase
  endfunction

  function automatic longint octave_noise(longint x, longint y, logic [31:0] f,
                                          logic [31:0] s);
    longint      px, py, fx, fy, u, v, one_l, fl;
    longint      n00, n10, n01, n11;
    logic [31:0] x0, y0, x1, y1;
    one_l = ONE;
    fl = f;
    px = x * fl;
    py = y * fl;
    fx = (px >> FRAC_BITS) & (one_l - 1);
    fy = (py >> FRAC_BITS) & (one_l - 1);
    x0 = px[63:32];
    y0 = py[63:32];
    x1 = x0 + 1;
    y1 = y0 + 1;
    u = quintic(fx);
    v = quintic(fy);
    n00 = corner_dot(corner_hash(x0, y0, s), fx, fy);
    n10 = corner_dot(corner_hash(x1, y0, s), fx - one_l, fy);
    n01 = corner_dot(corner_hash(x0, y1, s), fx, fy - one_l);
    n11 = corner_dot(corner_hash(x1, y1, s), fx - one_l, fy - one_l);
    return mix(mix(n00, n10, u), mix(n01, n11, u), v);
  endfunction

  function automatic logic signed [OUT_W-1:0] fbm_noise(sample_t smp);
    longint acc, total, q, n, an, amp, freq, x, y;
    int     cnt;
    acc = 0;
    total = 0;
    q = 0;
    x = smp.x;
    y = smp.y;
    freq = freq_r;
    amp = ONE;
    cnt = (oct_r > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF : oct_r;
    for (int i = 0; i < cnt; i++) begin
      n = octave_noise(x, y, freq[31:0], seed_r + i);
      an = (n < 0) ? -n : n;
      if (mode_r == MODE_RIDGED) n = ONE - an;
      else if (mode_r == MODE_BILLOW) n = an;
      acc += n * amp;
      total += amp;
      amp = (amp * longint'(pers_r)) >> FRAC_BITS;
      if (amp > 64'hFFFF_FFFF) amp = 64'hFFFF_FFFF;
      freq = (freq * longint'(lac_r)) >> FRAC_BITS;
      if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
    end
    if (total > 0) q = acc / total;
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    return q[OUT_W-1:0];
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OCTAVES: oct_r = data[OCT_W-1:0];
      CFG_MODE:    mode_r = data[MODE_W-1:0];
      CFG_SEED:    seed_r = data;
      CFG_FREQ:    freq_r = data;
      CFG_PERS:    pers_r = data[PERS_W-1:0];
      CFG_LAC:     lac_r = data[LAC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] o, logic [31:0] m, logic [31:0] s,
                           logic [31:0] f, logic [31:0] p, logic [31:0] l);
    write_reg(CFG_OCTAVES, o);
    write_reg(CFG_MODE, m);
    write_reg(CFG_SEED, s);
    write_reg(CFG_FREQ, f);
    write_reg(CFG_PERS, p);
    write_reg(CFG_LAC, l);
  endtask

  task automatic push_sample(logic [31:0] x, logic [31:0] y);
    sample_t smp;
    smp.x = x;
    smp.y = y;
    samples_pending.push_back(smp);
  endtask

  task automatic push_corners();
    push_sample(32'h0000_0000, 32'h0000_0000);
    push_sample(32'h8000_0000, 32'h8000_0000);
    push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_sample(32'h8000_0000, 32'h7FFF_FFFF);
    push_sample(32'hFFFF_FFFF, 32'h0000_0001);
    push_sample(32'h0000_8000, 32'hFFFF_8000);
    push_sample(32'h0001_0000, 32'h0003_C000);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (samples_pending.size() != 0 || start || noise_expected.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000);
      2: return -$urandom_range(0, 32'h0004_0000);
      default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      x_coord <= '0;
      y_coord <= '0;
      idle_left <= 0;
    end else begin
      if (start && !busy) noise_expected.push_back(fbm_noise({x_coord, y_coord}));
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
          idle_left <= $urandom_range(0, 16);
          start <= 1'b0;
        end else if (samples_pending.size() != 0) begin
          sample_t smp;
          smp = samples_pending.pop_front();
          x_coord <= smp.x;
          y_coord <= smp.y;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (noise_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: noise_value=%0d", noise_value);
      end else begin
        logic signed [OUT_W-1:0] want;
        want = noise_expected.pop_front();
        if (noise_value !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise_value mismatch: expected %0d, got %0d", want, noise_value);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    no_idle = 1'b0;
    oct_r = RST_OCTAVES;
    mode_r = MODE_PLAIN;
    seed_r = '0;
    freq_r = RST_FREQ;
    pers_r = RST_PERS;
    lac_r = RST_LAC;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    push_corners();
    drain();
    // zero octaves
    write_reg(CFG_OCTAVES, 0);
    push_corners();
    drain();
    // octave count saturation, frequency and weight overflow
    write_all(15, MODE_BILLOW, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h3FFFF, 32'hFFFFF);
    push_corners();
    drain();
    write_all(8, MODE_RIDGED, 32'h8000_0000, 32'h0002_8000, 32'h1_0000, 32'h2_0000);
    push_corners();
    drain();
    // unused mode, zero factors, spare indexes ignored
    write_all(9, 3, 32'hFFFF_FFFF, 0, 0, 0);
    write_reg(CFG_SPARE, $urandom);
    write_reg(CFG_TOP, $urandom);
    push_corners();
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      logic [31:0] o, f, p, l;
      o = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      f = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000);
      p = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32'h3FFFF)
                                      : $urandom_range(0, 32'h1_0000);
      l = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32'hFFFFF)
                                      : $urandom_range(32'h1_0000, 32'h4_0000);
      write_all(o, $urandom_range(0, 3), $urandom, f, p, l);
      if (ph == 11) no_idle = 1'b1;
      for (int k = 0; k < 118; k++) push_sample(rand_word(), rand_word());
      drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/fgn_pkg.sv
hdl/fgn_octave.sv
hdl/fgn_div_cell.sv
hdl/fractal_gradient_noise_core.sv
hdl/fgn_checker.sv
dv/fractal_gradient_noise_core_tb.sv
